/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssll check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssll check failed");

`endif

/* hw/rtl/ssll_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted linked list package
// Field widths, command codes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssll_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned SIZE_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic accept;
    logic clear;
    logic walk;
    logic upd1;
    logic upd2;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic walk_stop;
    logic found;
    logic out_free;
    cmd_e cmd;
  } st_t;

endpackage

`default_nettype wire

/* hw/rtl/ssll_intf.sv */
// ----------------------------------------------------------------------------
// Sorted linked list channels
// Command and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssll_req_if import ssll_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink (input valid, command, key, output ready);
endinterface

interface ssll_rsp_if import ssll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              success;
  logic [SLOT_W-1:0] slot;
  logic [SIZE_W-1:0] list_size;

  modport source (output valid, success, slot, list_size, input ready);
  modport sink (input valid, success, slot, list_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sorted_static_linked_list.sv */
// ----------------------------------------------------------------------------
// Sorted static linked list
// Ordered signed keys in a slot array with a used chain and a free chain.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  req_i    in   command, key
//  rsp_o    out  success, slot, list_size
//
// One word at a time. Clear and an insert into a full array go from accept straight to the
// result register; search and a failed insert or delete first walk the used chain, and a
// successful insert or delete then makes two link updates. The walk steps one link a cycle.
// Reset and clear restore the empty list through a fill mark, with no sweep.
// A stalled result sits in the output register while the next word is taken.
`default_nettype none

module sorted_static_linked_list import ssll_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssll_req_if.sink          req_i,
  ssll_rsp_if.source        rsp_o
);

  ctl_t ctl;
  st_t  st;

  ssll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .command_i   (req_i.command),
    .st_i        (st),
    .ctl_o       (ctl)
  );

  ssll_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .st_o            (st),
    .command_i       (req_i.command),
    .key_i           (req_i.key),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_success_o   (rsp_o.success),
    .rsp_slot_o      (rsp_o.slot),
    .rsp_list_size_o (rsp_o.list_size)
  );

endmodule

`default_nettype wire

/* hw/rtl/ssll_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted linked list controller
// Sequences accept, chain walk, two link updates and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ssll_ctrl import ssll_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [CMD_W-1:0] command_i,
  input  st_t              st_i,
  output ctl_t             ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_UPD1 = 5'b00100,
    S_UPD2 = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    ctl_o       = '0;
    req_ready_o = 1'b0;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.accept = 1'b1;
          if (cmd == CMD_CLEAR) begin
            ctl_o.clear = 1'b1;
            state_d     = S_RESP;
          end else if (cmd == CMD_INSERT && st_i.full) begin
            state_d = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        ctl_o.walk = 1'b1;
        if (st_i.walk_stop) begin
          unique case (st_i.cmd)
            CMD_INSERT: state_d = st_i.found ? S_RESP : S_UPD1;
            CMD_DELETE: state_d = st_i.found ? S_UPD1 : S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_UPD1: begin
        ctl_o.upd1 = 1'b1;
        state_d    = S_UPD2;
      end
      S_UPD2: begin
        ctl_o.upd2 = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          ctl_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ssll_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted linked list datapath
// Key and link memories, chain pointers, walk compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssll_datapath import ssll_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctl_t                    ctl_i,
  output st_t                     st_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic                    rsp_success_o,
  output logic [SLOT_W-1:0]       rsp_slot_o,
  output logic [SIZE_W-1:0]       rsp_list_size_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  function automatic logic [LW-1:0] norm(input logic [LW-1:0] v);
    return (v >= NONE) ? NONE : v;
  endfunction

  logic signed [KEY_W-1:0] key_mem [SLOTS];
  logic [LW-1:0]           link_mem [SLOTS];

  logic [LW-1:0] head_q, head_d, free_q, free_d, count_q, count_d, hw_q, hw_d;
  logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, steps_q, steps_d, succ_q, succ_d;
  logic          res_ok_q, res_ok_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  cmd_e          cmd_q;
  logic signed [KEY_W-1:0] key_q, key_a_q;
  logic [LW-1:0] link_a_q, link_b_q, link_a_n, link_b_n;
  logic          lw_en, kw_en;
  logic [LW-1:0] lw_addr, lw_data;
  logic          cur_none, step_lim, walk_stop, found;
  logic          out_valid_q, out_ok_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [SIZE_W-1:0] out_size_q;

  // Slots at or above the fill mark were never linked and still chain to the next slot.
  assign link_a_n = norm((cur_q >= hw_q) ? cur_q + LW'(1) : link_a_q);
  assign link_b_n = norm((free_q >= hw_q) ? free_q + LW'(1) : link_b_q);

  assign cur_none  = cur_q >= NONE;
  assign step_lim  = steps_q == NONE;
  assign walk_stop = cur_none || step_lim || !(key_a_q < key_q);
  assign found     = !cur_none && !step_lim && (key_a_q == key_q);

  always_comb begin
    head_d     = head_q;
    free_d     = free_q;
    count_d    = count_q;
    hw_d       = hw_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    succ_d     = succ_q;
    res_ok_d   = res_ok_q;
    res_slot_d = res_slot_q;
    lw_en      = 1'b0;
    kw_en      = 1'b0;
    lw_addr    = cur_q;
    lw_data    = free_q;
    if (ctl_i.accept) begin
      cur_d      = norm(head_q);
      prev_d     = NONE;
      steps_d    = '0;
      res_ok_d   = 1'b0;
      res_slot_d = '0;
    end
    if (ctl_i.clear) begin
      head_d   = NONE;
      free_d   = '0;
      count_d  = '0;
      hw_d     = '0;
      res_ok_d = 1'b1;
    end
    if (ctl_i.walk) begin
      if (!walk_stop) begin
        prev_d  = cur_q;
        cur_d   = link_a_n;
        steps_d = steps_q + LW'(1);
      end else begin
        succ_d = link_a_n;
        if (cmd_q == CMD_SEARCH && found) begin
          res_ok_d   = 1'b1;
          res_slot_d = cur_q[IW-1:0];
        end
      end
    end
    if (ctl_i.upd1) begin
      lw_en    = 1'b1;
      res_ok_d = 1'b1;
      if (cmd_q == CMD_INSERT) begin
        lw_addr    = free_q;
        lw_data    = cur_q;
        kw_en      = 1'b1;
        free_d     = link_b_n;
        res_slot_d = free_q[IW-1:0];
        count_d    = count_q + LW'(1);
        if (free_q == hw_q) begin
          hw_d = hw_q + LW'(1);
        end
      end else begin
        lw_addr    = cur_q;
        lw_data    = free_q;
        free_d     = cur_q;
        res_slot_d = cur_q[IW-1:0];
        if (count_q != '0) begin
          count_d = count_q - LW'(1);
        end
      end
    end
    if (ctl_i.upd2) begin
      lw_data = (cmd_q == CMD_INSERT) ? LW'(res_slot_q) : succ_q;
      lw_addr = prev_q;
      if (prev_q >= NONE) begin
        head_d = lw_data;
      end else begin
        lw_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_d < NONE) begin
      key_a_q  <= key_mem[cur_d[IW-1:0]];
      link_a_q <= link_mem[cur_d[IW-1:0]];
    end
    if (free_q < NONE) begin
      link_b_q <= link_mem[free_q[IW-1:0]];
    end
    if (lw_en) begin
      link_mem[lw_addr[IW-1:0]] <= lw_data;
    end
    if (kw_en) begin
      key_mem[free_q[IW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NONE;
      free_q      <= '0;
      count_q     <= '0;
      hw_q        <= '0;
      cmd_q       <= CMD_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
      hw_q    <= hw_d;
      if (ctl_i.accept) begin
        cmd_q <= cmd_e'(command_i);
      end
      if (ctl_i.load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    steps_q    <= steps_d;
    succ_q     <= succ_d;
    res_ok_q   <= res_ok_d;
    res_slot_q <= res_slot_d;
    if (ctl_i.accept) begin
      key_q <= key_i;
    end
    if (ctl_i.load) begin
      out_ok_q   <= res_ok_q;
      out_slot_q <= SLOT_W'(res_slot_q);
      out_size_q <= SIZE_W'(count_q);
    end
  end

  assign st_o.full      = free_q >= NONE;
  assign st_o.walk_stop = walk_stop;
  assign st_o.found     = found;
  assign st_o.out_free  = !out_valid_q || rsp_ready_i;
  assign st_o.cmd       = cmd_q;

  assign rsp_valid_o     = out_valid_q;
  assign rsp_success_o   = out_ok_q;
  assign rsp_slot_o      = out_slot_q;
  assign rsp_list_size_o = out_size_q;

endmodule

`default_nettype wire

/* hw/rtl/ssll_checker.sv */
// ----------------------------------------------------------------------------
// Sorted linked list checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssll_checker import ssll_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic              rsp_success_i,
  input wire logic [SLOT_W-1:0] rsp_slot_i,
  input wire logic [SIZE_W-1:0] rsp_size_i
);

  `SSLL_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_success_i) && $stable(rsp_slot_i) && $stable(rsp_size_i))
  `SSLL_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `SSLL_ASSERT_SAME(a_fail_slot_zero, clk_i, rst_ni, rsp_valid_i && !rsp_success_i, rsp_slot_i == '0)
  `SSLL_ASSERT_SAME(a_size_bound, clk_i, rst_ni, rsp_valid_i, (SLOTS > 16) || (rsp_size_i <= SIZE_W'(SLOTS)))

endmodule

bind sorted_static_linked_list ssll_checker #(
  .SLOTS (SLOTS)
) u_ssll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_success_i (rsp_o.success),
  .rsp_slot_i    (rsp_o.slot),
  .rsp_size_i    (rsp_o.list_size)
);

`default_nettype wire

/* verif/sorted_static_linked_list_test.sv */
// ----------------------------------------------------------------------------
// Sorted static linked list testbench
// Drives insert, delete, search and clear words into the list with random
// idle gaps on both channels. Each accepted word is run through a local model
// of the ordered slot array and its free chain, and every result word is compared
// field by field with the oldest outstanding expectation: a typed row's table entry, else the model's.
// ----------------------------------------------------------------------------
module sorted_static_linked_list_test;
  import ssll_pkg::*;

  localparam int unsigned NSLOT       = SLOTS_DEF;
  localparam int unsigned NO_LINK     = NSLOT;
  localparam int unsigned RANDOM_WORDS = 1975;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] list_size;
  } list_reply_t;

  typedef struct {
    cmd_e                    op;
    logic signed [KEY_W-1:0] key;
    bit                      typed;
    list_reply_t             want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssll_req_if req_if ();
  ssll_rsp_if rsp_if ();

  sorted_static_linked_list dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [KEY_W-1:0] slot_key [NSLOT];
  int unsigned             slot_next [NSLOT];
  int unsigned             used_head;
  int unsigned             free_top;
  int unsigned             held_count;

  list_reply_t             pending [$];
  stim_row_t               rows [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned errors;
  int unsigned printed;
  int unsigned checked;
  int unsigned hits;
  int unsigned full_seen;
  int unsigned op_count [4];
  int unsigned calm_left;
  bit          sink_hold_req;

  task automatic report_mismatch(input string msg);
    errors++;
    if (printed < PRINT_LIMIT) begin
      printed++;
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned link_at(input int unsigned s);
    if (s >= NSLOT) return NO_LINK;
    return (slot_next[s] >= NSLOT) ? NO_LINK : slot_next[s];
  endfunction

  function automatic void empty_list();
    for (int unsigned i = 0; i < NSLOT; i++) begin
      slot_next[i] = i + 1;
    end
    used_head  = NO_LINK;
    free_top   = 0;
    held_count = 0;
  endfunction

  // Walks the used chain to the first key that is not below k.
  function automatic void find_place(input logic signed [KEY_W-1:0] k,
                                     output int unsigned hit, output int unsigned prv);
    int unsigned p;
    int unsigned s;
    int unsigned steps;
    p = NO_LINK;
    s = (used_head >= NSLOT) ? NO_LINK : used_head;
    steps = 0;
    while (s != NO_LINK && steps < NSLOT && slot_key[s] < k) begin
      p = s;
      s = link_at(s);
      steps++;
    end
    if (steps >= NSLOT) s = NO_LINK;
    hit = s;
    prv = p;
  endfunction

  function automatic list_reply_t predict_reply(input cmd_e op,
                                                input logic signed [KEY_W-1:0] k);
    list_reply_t r;
    int unsigned hit;
    int unsigned prv;
    int unsigned n;
    r = '0;
    case (op)
      CMD_INSERT: begin
        if (free_top < NSLOT) begin
          find_place(k, hit, prv);
          if (!(hit != NO_LINK && slot_key[hit] == k)) begin
            n = free_top;
            free_top = link_at(n);
            slot_key[n] = k;
            if (prv == NO_LINK) begin
              slot_next[n] = (used_head >= NSLOT) ? NO_LINK : used_head;
              used_head = n;
            end else begin
              slot_next[n] = link_at(prv);
              slot_next[prv] = n;
            end
            held_count++;
            r.success = 1'b1;
            r.slot = SLOT_W'(n);
          end
        end else begin
          full_seen++;
        end
      end
      CMD_DELETE: begin
        find_place(k, hit, prv);
        if (hit != NO_LINK && slot_key[hit] == k) begin
          if (prv == NO_LINK) used_head = link_at(hit);
          else slot_next[prv] = link_at(hit);
          slot_next[hit] = (free_top >= NSLOT) ? NO_LINK : free_top;
          free_top = hit;
          if (held_count > 0) held_count--;
          r.success = 1'b1;
          r.slot = SLOT_W'(hit);
        end
      end
      CMD_SEARCH: begin
        find_place(k, hit, prv);
        if (hit != NO_LINK && slot_key[hit] == k) begin
          r.success = 1'b1;
          r.slot = SLOT_W'(hit);
        end
      end
      default: begin
        empty_list();
        r.success = 1'b1;
      end
    endcase
    r.list_size = SIZE_W'(held_count);
    return r;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_row(input cmd_e op, input logic signed [KEY_W-1:0] k,
                                  input bit typed, input logic ok,
                                  input int unsigned slot, input int unsigned size);
    stim_row_t row;
    row.op = op;
    row.key = k;
    row.typed = typed;
    row.want.success = ok;
    row.want.slot = SLOT_W'(slot);
    row.want.list_size = SIZE_W'(size);
    rows.push_back(row);
  endfunction

  task automatic send_word(input cmd_e op, input logic signed [KEY_W-1:0] k,
                           input bit typed, input list_reply_t want);
    int unsigned gap;
    list_reply_t predicted;
    gap = 0;
    if (calm_left > 0) calm_left--;
    else gap = idle_gap();
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= op;
    req_if.key <= k;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_reply(op, k);
    pending.push_back(typed ? want : predicted);
    op_count[op]++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending.size() != 0);
  endtask

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending.size() == 0) begin
        report_mismatch("result word with no outstanding command");
      end else begin
        want = pending.pop_front();
        checked++;
        if (rsp_if.success === 1'b1) hits++;
        if (rsp_if.success !== want.success)
          report_mismatch($sformatf("success got %b want %b", rsp_if.success, want.success));
        if (rsp_if.slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d", rsp_if.slot, want.slot));
        if (rsp_if.list_size !== want.list_size)
          report_mismatch($sformatf("list_size got %0d want %0d",
                                    rsp_if.list_size, want.list_size));
      end
    end
  end

  initial begin : result_ready
    int unsigned len;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end
      rsp_if.ready <= 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (len) @(posedge clk_i);
      len = idle_gap();
      if (len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("sorted_static_linked_list_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    cmd_e                    op;
    logic signed [KEY_W-1:0] k;
    list_reply_t             none;
    int unsigned             r;
    int unsigned             ins_pct;
    int unsigned             guard;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_CLEAR;
    req_if.key <= '0;
    errors = 0;
    printed = 0;
    checked = 0;
    hits = 0;
    full_seen = 0;
    calm_left = 0;
    sink_hold_req = 1'b0;
    none = '0;
    foreach (op_count[i]) op_count[i] = 0;
    empty_list();

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i < 16) key_pool[i] = int'($urandom_range(0, 40)) - 20;
      else key_pool[i] = $urandom;
    end

    add_row(CMD_CLEAR, 5, 1, 1'b1, 0, 0);
    add_row(CMD_SEARCH, 0, 1, 1'b0, 0, 0);
    add_row(CMD_DELETE, 32'sh8000_0000, 1, 1'b0, 0, 0);
    add_row(CMD_INSERT, 32'sh8000_0000, 1, 1'b1, 0, 1);
    add_row(CMD_INSERT, 32'sh7fff_ffff, 1, 1'b1, 1, 2);
    add_row(CMD_INSERT, 32'sh8000_0000, 1, 1'b0, 0, 2);
    add_row(CMD_SEARCH, 32'sh7fff_ffff, 1, 1'b1, 1, 2);
    add_row(CMD_DELETE, 32'sh8000_0000, 1, 1'b1, 0, 1);
    add_row(CMD_INSERT, -1, 1, 1'b1, 0, 2);
    add_row(CMD_INSERT, 1000, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, -1000, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 7, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, -7, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 500, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 3, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, -300, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 42, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 2, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, -2, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 99, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 1, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 123456, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, -123456, 0, 1'b0, 0, 0);
    add_row(CMD_INSERT, 8, 1, 1'b0, 0, 16);
    add_row(CMD_CLEAR, -1, 1, 1'b1, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_word(rows[i].op, rows[i].key, rows[i].typed, rows[i].want);

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 600) sink_hold_req = 1'b1;
      if (i == 1000 || i == 1500) drain_results();
      ins_pct = ((i / 150) % 2 == 0) ? 65 : 25;
      r = $urandom_range(0, 99);
      if (r < 2) op = CMD_CLEAR;
      else if (r < 2 + ins_pct) op = CMD_INSERT;
      else if (r < 2 + ins_pct + (98 - ins_pct) / 2) op = CMD_DELETE;
      else op = CMD_SEARCH;
      if ($urandom_range(0, 3) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_word(op, k, 1'b0, none);
    end

    req_if.valid <= 1'b0;
    guard = 0;
    while (pending.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (pending.size() != 0) begin
      void'(pending.pop_front());
      report_mismatch("expected result word never arrived");
    end

    $display("Covered %0d insert, %0d delete, %0d search and %0d clear words.",
             op_count[CMD_INSERT], op_count[CMD_DELETE], op_count[CMD_SEARCH],
             op_count[CMD_CLEAR]);
    $display("Checked %0d results, %0d successful, %0d inserts into a full list, %0d errors.",
             checked, hits, full_seen, errors);
    if (errors == 0) begin
      $display("sorted_static_linked_list_test OK");
    end else begin
      $display("sorted_static_linked_list_test NOT OK");
    end
    $finish;
  end

endmodule
